>>> sv/l4pc_pkg.sv
`timescale 1ns / 1ps

package l4pc_pkg;

  localparam int COUNT_W    = 17;
  localparam int MAX_PACKET = 65536;
  localparam int HDR_BYTES  = 20;
  localparam int PAY_BYTES  = 8;

  localparam logic [15:0] TLS_PORT_RESET = 16'd443;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [7:0] TLS_HANDSHAKE = 8'h16;
  localparam logic [7:0] TLS_MAJOR     = 8'h03;
  localparam logic [7:0] TLS_MINOR_MAX = 8'h04;

  localparam logic [1:0] CLASS_TCP   = 2'd0;
  localparam logic [1:0] CLASS_UDP   = 2'd1;
  localparam logic [1:0] CLASS_HTTP  = 2'd2;
  localparam logic [1:0] CLASS_HTTPS = 2'd3;

  localparam int HTTP_PREFIXES = 10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } pkt_item_t;

  typedef struct packed {
    logic [1:0]         packet_class;
    logic [31:0]        src_addr;
    logic [31:0]        dst_addr;
    logic [15:0]        src_port;
    logic [15:0]        dst_port;
    logic [COUNT_W-1:0] payload_length;
  } res_item_t;

  // first character in the top byte, unused bytes zero
  function automatic logic [63:0] http_prefix(input logic [3:0] idx);
    logic [63:0] text;
    case (idx)
      4'd0:    text = 64'h4745_5420_0000_0000;
      4'd1:    text = 64'h504F_5354_2000_0000;
      4'd2:    text = 64'h5055_5420_0000_0000;
      4'd3:    text = 64'h4445_4C45_5445_2000;
      4'd4:    text = 64'h4845_4144_2000_0000;
      4'd5:    text = 64'h4F50_5449_4F4E_5320;
      4'd6:    text = 64'h5452_4143_4520_0000;
      4'd7:    text = 64'h434F_4E4E_4543_5420;
      4'd8:    text = 64'h5041_5443_4820_0000;
      4'd9:    text = 64'h4854_5450_2F31_2E00;
      default: text = 64'h0;
    endcase
    return text;
  endfunction

  function automatic logic [3:0] http_prefix_len(input logic [3:0] idx);
    logic [3:0] n;
    case (idx)
      4'd0:    n = 4'd4;
      4'd1:    n = 4'd5;
      4'd2:    n = 4'd4;
      4'd3:    n = 4'd7;
      4'd4:    n = 4'd5;
      4'd5:    n = 4'd8;
      4'd6:    n = 4'd6;
      4'd7:    n = 4'd8;
      4'd8:    n = 4'd6;
      4'd9:    n = 4'd7;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

>>> sv/ipv4_l4_packet_classifier_unit.sv
`timescale 1ns / 1ps

// Classifies raw IPv4 packets fed one byte per transaction on pkt, with last
// marking the final byte. One byte is accepted every cycle while pkt_stall is
// low; header fields, transport ports and the first eight payload bytes are
// captured as the bytes stream past, so nothing is stored beyond them. The
// last byte sets pkt_len and cls_pend; the classification is then formed from
// the captured fields and lands in the output register, offered on res.
// TCP and UDP packets give one result (TCP, UDP, HTTP or HTTPS); short
// packets and other protocols give none. pkt_stall rises only while a
// finished result is stalled in the output register and the next packet's
// classification is also waiting. tls_port may be written through cfg at any
// time the block is idle; cfg_ready is always high.
module ipv4_l4_packet_classifier_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                pkt_valid,
  output logic                pkt_stall,
  input  l4pc_pkg::pkt_item_t pkt,
  output logic                res_valid,
  input  logic                res_stall,
  output l4pc_pkg::res_item_t res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  logic [l4pc_pkg::COUNT_W-1:0] byte_count;
  logic [l4pc_pkg::COUNT_W-1:0] byte_count_next;
  logic [l4pc_pkg::COUNT_W-1:0] count_inc;
  logic [l4pc_pkg::COUNT_W-1:0] pkt_len;
  logic [15:0]                  tls_port;
  logic [3:0]                   ihl;
  logic [7:0]                   proto;
  logic [31:0]                  src_addr;
  logic [31:0]                  dst_addr;
  logic [7:0]                   hdr [l4pc_pkg::HDR_BYTES];
  logic [7:0]                   cap [l4pc_pkg::PAY_BYTES];
  logic                         cls_pend;

  logic       accept;
  logic       adv;
  logic       head;
  logic [6:0] pos;
  logic [3:0] ihl_cur;
  logic [6:0] hdr_base;
  logic [6:0] hdr_rel;
  logic       hdr_hit;
  logic [6:0] cap_rel;
  logic       cap_hit;

  logic [5:0]                   ip_len;
  logic [3:0]                   doff;
  logic [6:0]                   poff;
  logic [7:0]                   pay [l4pc_pkg::PAY_BYTES];
  logic [15:0]                  sport;
  logic [15:0]                  dport;
  logic [l4pc_pkg::COUNT_W-1:0] tcp_plen;
  logic [l4pc_pkg::COUNT_W-1:0] udp_plen;
  logic                         base_ok;
  logic                         tcp_ok;
  logic                         udp_ok;
  logic                         tls_hit;
  logic                         http_hit;
  l4pc_pkg::res_item_t          res_next;

  assign cfg_ready = 1'b1;
  assign adv       = !res_valid || !res_stall;
  assign pkt_stall = cls_pend && !adv;
  assign accept    = pkt_valid && !pkt_stall;

  assign head = (byte_count[l4pc_pkg::COUNT_W-1:7] == '0);
  assign pos  = byte_count[6:0];

  always_comb begin
    if (byte_count < l4pc_pkg::COUNT_W'(l4pc_pkg::MAX_PACKET)) begin
      count_inc = byte_count + l4pc_pkg::COUNT_W'(1);
    end else begin
      count_inc = byte_count;
    end
    byte_count_next = pkt.last ? '0 : count_inc;
  end

  // transport header window, relative to 4*IHL of this packet
  assign ihl_cur  = (pos == 7'd0) ? pkt.data_byte[3:0] : ihl;
  assign hdr_base = {1'b0, ihl_cur, 2'b00};
  assign hdr_rel  = pos - hdr_base;
  assign hdr_hit  = head && (pos >= hdr_base) &&
                    (hdr_rel < 7'(l4pc_pkg::HDR_BYTES));

  assign ip_len = {ihl, 2'b00};
  assign doff   = hdr[12][7:4];
  assign poff   = {1'b0, ip_len} + {1'b0, doff, 2'b00};

  // payload captured from its start when the data offset is four or more words
  assign cap_rel = pos - poff;
  assign cap_hit = head && (doff[3:2] != 2'b00) && (pos >= poff) &&
                   (cap_rel < 7'(l4pc_pkg::PAY_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      cls_pend   <= 1'b0;
      tls_port   <= l4pc_pkg::TLS_PORT_RESET;
    end else begin
      if (cfg_valid) begin
        tls_port <= cfg_data;
      end
      if (accept) begin
        byte_count <= byte_count_next;
      end
      if (accept && pkt.last) begin
        cls_pend <= 1'b1;
      end else if (adv) begin
        cls_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (head) begin
        case (pos)
          7'd0:    ihl <= pkt.data_byte[3:0];
          7'd9:    proto <= pkt.data_byte;
          7'd12:   src_addr[31:24] <= pkt.data_byte;
          7'd13:   src_addr[23:16] <= pkt.data_byte;
          7'd14:   src_addr[15:8] <= pkt.data_byte;
          7'd15:   src_addr[7:0] <= pkt.data_byte;
          7'd16:   dst_addr[31:24] <= pkt.data_byte;
          7'd17:   dst_addr[23:16] <= pkt.data_byte;
          7'd18:   dst_addr[15:8] <= pkt.data_byte;
          7'd19:   dst_addr[7:0] <= pkt.data_byte;
          default: ;
        endcase
      end
      if (hdr_hit) begin
        hdr[hdr_rel[4:0]] <= pkt.data_byte;
      end
      if (cap_hit) begin
        cap[cap_rel[2:0]] <= pkt.data_byte;
      end
      if (pkt.last) begin
        pkt_len <= count_inc;
      end
    end
  end

  // short data offsets put the payload start inside the captured window
  always_comb begin
    for (int i = 0; i < l4pc_pkg::PAY_BYTES; i++) begin
      case (doff)
        4'd0:    pay[i] = hdr[i];
        4'd1:    pay[i] = hdr[i + 4];
        4'd2:    pay[i] = hdr[i + 8];
        4'd3:    pay[i] = hdr[i + 12];
        default: pay[i] = cap[i];
      endcase
    end
  end

  assign sport = {hdr[0], hdr[1]};
  assign dport = {hdr[2], hdr[3]};

  assign tcp_plen = pkt_len - l4pc_pkg::COUNT_W'(poff);
  assign udp_plen = pkt_len - l4pc_pkg::COUNT_W'(ip_len) - l4pc_pkg::COUNT_W'(8);

  assign base_ok = (pkt_len >= l4pc_pkg::COUNT_W'(20)) &&
                   (pkt_len >= l4pc_pkg::COUNT_W'(ip_len));
  assign tcp_ok  = base_ok && (proto == l4pc_pkg::PROTO_TCP) &&
                   (pkt_len >= l4pc_pkg::COUNT_W'(ip_len) + l4pc_pkg::COUNT_W'(20)) &&
                   (pkt_len > l4pc_pkg::COUNT_W'(poff));
  assign udp_ok  = base_ok && (proto == l4pc_pkg::PROTO_UDP) &&
                   (pkt_len >= l4pc_pkg::COUNT_W'(ip_len) + l4pc_pkg::COUNT_W'(8));

  assign tls_hit = ((sport == tls_port) || (dport == tls_port)) &&
                   (tcp_plen >= l4pc_pkg::COUNT_W'(5)) &&
                   (pay[0] == l4pc_pkg::TLS_HANDSHAKE) &&
                   (pay[1] == l4pc_pkg::TLS_MAJOR) &&
                   (pay[2] <= l4pc_pkg::TLS_MINOR_MAX);

  always_comb begin
    logic [63:0] text;
    logic [3:0]  n;
    logic        same;
    http_hit = 1'b0;
    for (int k = 0; k < l4pc_pkg::HTTP_PREFIXES; k++) begin
      text = l4pc_pkg::http_prefix(4'(k));
      n    = l4pc_pkg::http_prefix_len(4'(k));
      same = (tcp_plen >= l4pc_pkg::COUNT_W'(n));
      for (int j = 0; j < l4pc_pkg::PAY_BYTES; j++) begin
        if ((4'(j) < n) && (pay[j] != text[63 - 8*j -: 8])) begin
          same = 1'b0;
        end
      end
      http_hit = http_hit | same;
    end
  end

  always_comb begin
    res_next.src_addr = src_addr;
    res_next.dst_addr = dst_addr;
    res_next.src_port = sport;
    res_next.dst_port = dport;
    if (proto == l4pc_pkg::PROTO_UDP) begin
      res_next.packet_class   = l4pc_pkg::CLASS_UDP;
      res_next.payload_length = udp_plen;
    end else begin
      res_next.payload_length = tcp_plen;
      if (tls_hit) begin
        res_next.packet_class = l4pc_pkg::CLASS_HTTPS;
      end else if (http_hit) begin
        res_next.packet_class = l4pc_pkg::CLASS_HTTP;
      end else begin
        res_next.packet_class = l4pc_pkg::CLASS_TCP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= cls_pend && (tcp_ok || udp_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cls_pend) begin
      res <= res_next;
    end
  end

endmodule
